// ----- src/hxr_pkg.sv -----
// ----------------------------------------------------------------------------
// hxr_pkg: load-cell converter serial reader, shared types
// Request and result payloads, configuration bundle, command and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hxr_pkg;

	localparam int SAMPLE_W = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_PDOWN = 2'd2
	} op_t;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PULSES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PDOWN_TICKS = 2'd3;

	localparam logic [1:0]  GAIN_PULSES_RST = 2'd1;
	localparam logic [7:0]  HALF_PERIOD_RST = 8'd1;
	localparam logic [23:0] TIMEOUT_RST     = 24'd0;
	localparam logic [9:0]  PDOWN_TICKS_RST = 10'd64;

	typedef struct packed {
		logic [1:0] op;
		logic       data_in;
		logic       wait_settle;
	} in_item_t;

	typedef struct packed {
		logic                       clock_out;
		logic                       busy_res;
		logic                       sample_valid;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       timed_out;
		logic                       powered_down;
	} out_item_t;

	typedef struct packed {
		logic [1:0]  gain_pulses;
		logic [7:0]  half_period_ticks;
		logic [23:0] timeout_ticks;
		logic [9:0]  power_down_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ----- src/hxr_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// hxr_cfg_regs: configuration register file
// Write-only registers for pulse count, half period, timeout and settle time.
// ----------------------------------------------------------------------------
`default_nettype none

module hxr_cfg_regs
	import hxr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_pulses       <= GAIN_PULSES_RST;
			cfg_q.half_period_ticks <= HALF_PERIOD_RST;
			cfg_q.timeout_ticks     <= TIMEOUT_RST;
			cfg_q.power_down_ticks  <= PDOWN_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GAIN_PULSES: cfg_q.gain_pulses       <= cfg_wdata[1:0];
				REG_HALF_PERIOD: cfg_q.half_period_ticks <= cfg_wdata[7:0];
				REG_TIMEOUT:     cfg_q.timeout_ticks     <= cfg_wdata[23:0];
				REG_PDOWN_TICKS: cfg_q.power_down_ticks  <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ----- src/hxr_seq.sv -----
// ----------------------------------------------------------------------------
// hxr_seq: serial clock sequencer
// Phase state, tick timer, bit counter and shift register; one step per tick.
// ----------------------------------------------------------------------------
`default_nettype none

module hxr_seq
	import hxr_pkg::*;
#(
	parameter int DATA_BITS   = 24,
	parameter int TIMER_WIDTH = 24
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	input  wire cfg_t     cfg,
	output out_item_t     res
);

	localparam int BW = $clog2(DATA_BITS + 4);
	localparam int CW = (TIMER_WIDTH > 24) ? TIMER_WIDTH : 24;
	localparam logic [CW-1:0] TMAX = CW'({TIMER_WIDTH{1'b1}});

	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_WAIT   = 6'b000010,
		PH_HIGH   = 6'b000100,
		PH_LOW    = 6'b001000,
		PH_PDLOW  = 6'b010000,
		PH_SETTLE = 6'b100000
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [BW-1:0]          bit_cnt_q, bit_cnt_d;
	logic [TIMER_WIDTH-1:0] tick_q, tick_d, tick_inc;
	logic [DATA_BITS-1:0]   shift_q, shift_d;
	logic                   clk_q, clk_d;
	logic                   settle_q, settle_d;

	logic [CW-1:0]       tick_ext, tmo_lim;
	logic [1:0]          gains;
	logic [BW-1:0]       bit_next;
	logic                valid, tmo;
	logic signed [SAMPLE_W-1:0] ext;

	assign tick_inc = (tick_q == '1) ? tick_q : tick_q + 1'b1;
	assign tick_ext = CW'(tick_inc);
	assign tmo_lim  = (CW'(cfg.timeout_ticks) > TMAX) ? TMAX : CW'(cfg.timeout_ticks);
	assign gains    = (cfg.gain_pulses == 2'd0) ? 2'd1 : cfg.gain_pulses;
	assign bit_next = bit_cnt_q + 1'b1;
	assign ext      = SAMPLE_W'(signed'(shift_d));

	always_comb begin
		phase_d   = phase_q;
		bit_cnt_d = bit_cnt_q;
		tick_d    = tick_q;
		shift_d   = shift_q;
		clk_d     = clk_q;
		settle_d  = settle_q;
		valid     = 1'b0;
		tmo       = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (item.op == OP_READ) begin
					clk_d     = 1'b0;
					phase_d   = PH_WAIT;
					tick_d    = '0;
					shift_d   = '0;
					bit_cnt_d = '0;
				end else if (item.op == OP_PDOWN) begin
					clk_d    = 1'b0;
					phase_d  = PH_PDLOW;
					tick_d   = '0;
					settle_d = item.wait_settle;
				end
			end
			PH_WAIT: begin
				if (!item.data_in) begin
					clk_d   = 1'b1;
					phase_d = PH_HIGH;
					tick_d  = '0;
				end else if (cfg.timeout_ticks != '0) begin
					tick_d = tick_inc;
					if (tick_ext >= tmo_lim) begin
						tmo     = 1'b1;
						phase_d = PH_IDLE;
						tick_d  = '0;
					end
				end
			end
			PH_HIGH: begin
				tick_d = tick_inc;
				if (tick_ext >= CW'(cfg.half_period_ticks)) begin
					clk_d   = 1'b0;
					phase_d = PH_LOW;
					tick_d  = '0;
				end
			end
			PH_LOW: begin
				tick_d = tick_inc;
				if (tick_ext >= CW'(cfg.half_period_ticks)) begin
					tick_d = '0;
					// shift data bits only; gain pulses sample nothing
					if (bit_cnt_q < BW'(DATA_BITS))
						shift_d = {shift_q[DATA_BITS-2:0], item.data_in};
					bit_cnt_d = bit_next;
					if (bit_next < BW'(DATA_BITS) + BW'(gains)) begin
						clk_d   = 1'b1;
						phase_d = PH_HIGH;
					end else begin
						valid     = 1'b1;
						phase_d   = PH_IDLE;
						bit_cnt_d = '0;
					end
				end
			end
			PH_PDLOW: begin
				tick_d = tick_inc;
				if (tick_ext >= CW'(cfg.half_period_ticks)) begin
					clk_d  = 1'b1;
					tick_d = '0;
					if (settle_q && cfg.power_down_ticks != '0)
						phase_d = PH_SETTLE;
					else
						phase_d = PH_IDLE;
				end
			end
			PH_SETTLE: begin
				tick_d = tick_inc;
				if (tick_ext >= CW'(cfg.power_down_ticks)) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_comb begin
		res.clock_out    = clk_d;
		res.busy_res     = (phase_d != PH_IDLE);
		res.sample_valid = valid;
		res.sample       = valid ? ext : '0;
		res.timed_out    = tmo;
		res.powered_down = clk_d && (phase_d == PH_IDLE || phase_d == PH_SETTLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			bit_cnt_q <= '0;
			tick_q    <= '0;
			shift_q   <= '0;
			clk_q     <= 1'b0;
			settle_q  <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			bit_cnt_q <= bit_cnt_d;
			tick_q    <= tick_d;
			shift_q   <= shift_d;
			clk_q     <= clk_d;
			settle_q  <= settle_d;
		end
	end

`ifndef SYNTH
	a_bits_only_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		(bit_cnt_q != '0) |-> (phase_q == PH_HIGH || phase_q == PH_LOW))
		else $error("bit counter running outside a read");
	a_clk_high_in_high: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HIGH) |-> clk_q)
		else $error("serial clock low during high half");
	a_clk_low_in_low: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LOW || phase_q == PH_WAIT || phase_q == PH_PDLOW) |-> !clk_q)
		else $error("serial clock high during low half");
`endif

endmodule

`default_nettype wire

// ----- src/load_cell_adc_serial_reader_top.sv -----
// ----------------------------------------------------------------------------
// load_cell_adc_serial_reader_top: load-cell converter serial reader
// Bit-serial read and power-down master driven by one request per timebase tick.
// ----------------------------------------------------------------------------
// Each request is one timebase tick with a command and the sampled data pin;
// one result leaves for every request, in order. One request is taken every
// clock cycle while in_stall is low; a result passes the input register, then
// the sequencer step into the result register. A stalled result holds the input
// register and stalls the request side only when both are full. The read
// sequence runs 24 data pulses plus 1 to 3 gain pulses at half_period_ticks
// ticks per half; configuration must be written while idle; nothing enforces it.
`default_nettype none

module load_cell_adc_serial_reader_top
	import hxr_pkg::*;
#(
	parameter int DATA_BITS   = 24,
	parameter int TIMER_WIDTH = 24
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t      cfg;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res;
	out_item_t res_s2;
	logic      valid_s2;
	logic      adv;
	logic      take;

	hxr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hxr_seq #(
		.DATA_BITS   (DATA_BITS),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// advance the held request when the result register can take it
	assign adv      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign take     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			item_s1 <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= res;
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

`ifndef SYNTH
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("request stalled with room in the pipeline");
	a_sample_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.sample_valid) |-> (!out_data.busy_res && !out_data.clock_out))
		else $error("sample given while sequence still busy");
	a_sample_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.sample_valid) |-> (out_data.sample == '0))
		else $error("nonzero sample without sample_valid");
	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.timed_out) |-> (!out_data.busy_res && !out_data.clock_out))
		else $error("timeout left the sequence running");
	a_pdown_clk_high: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.powered_down) |-> out_data.clock_out)
		else $error("powered down with serial clock low");
`endif

endmodule

`default_nettype wire
